// ===== sv/cos_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cos_pkg
// Shared types, codes and sizes of the chunked offset segmenter.
// ---------------------------------------------------------------------------
package cos_pkg;

    localparam int MAX_CHUNKS = 64;
    localparam int CHUNK_W    = 6;
    localparam int CNT_W      = 7;
    localparam int OFS_W      = 40;
    localparam int SIZE_W     = 32;
    localparam int DIV_STEPS  = 40;
    localparam int DIV_CNT_W  = 6;

    // Input mode codes.
    localparam logic [2:0] MODE_LOAD  = 3'd0;
    localparam logic [2:0] MODE_READ  = 3'd1;
    localparam logic [2:0] MODE_WRITE = 3'd2;
    localparam logic [2:0] MODE_MARK  = 3'd3;
    localparam logic [2:0] MODE_CLEAR = 3'd4;

    // Result status codes.
    localparam logic [2:0] STAT_OK     = 3'd0;
    localparam logic [2:0] STAT_OOB    = 3'd1;
    localparam logic [2:0] STAT_ABSENT = 3'd2;
    localparam logic [2:0] STAT_CONTIG = 3'd3;
    localparam logic [2:0] STAT_BAD    = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SIZE_MODE    = 3'd0;
    localparam logic [2:0] CFG_CONTIGUOUS   = 3'd1;
    localparam logic [2:0] CFG_CHUNK_BYTES  = 3'd2;
    localparam logic [2:0] CFG_BUFFER_BYTES = 3'd3;
    localparam logic [2:0] CFG_CHUNK_COUNT  = 3'd4;

    typedef enum logic [2:0] {
        OP_LOAD, OP_READ, OP_WRITE, OP_MARK, OP_CLEAR, OP_BAD
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV_TOT, S_DIV_OFF, S_SUM_RD, S_SUM_GO, S_CHECK,
        S_LOC_RD, S_LOC_GO, S_SEG_RD, S_SEG_GO, S_FLUSH
    } t_state;

    typedef struct packed {
        logic [2:0]         mode;
        logic [OFS_W-1:0]   byte_offset;
        logic [OFS_W-1:0]   byte_count;
        logic [CHUNK_W-1:0] entry_index;
        logic [SIZE_W-1:0]  entry_size;
    } t_in_item;

    typedef struct packed {
        logic [CHUNK_W-1:0] chunk_index;
        logic [SIZE_W-1:0]  chunk_pos;
        logic [SIZE_W-1:0]  segment_bytes;
        logic [OFS_W-1:0]   host_offset;
        logic               allocate_now;
        logic [2:0]         status;
        logic               last;
    } t_result;

    typedef struct packed {
        t_op                op;
        logic [OFS_W-1:0]   byte_offset;
        logic [OFS_W-1:0]   byte_count;
        logic [CHUNK_W-1:0] entry_index;
        logic [SIZE_W-1:0]  entry_size;
    } t_cmd;

    typedef struct packed {
        logic               size_mode;
        logic               contiguous;
        logic [SIZE_W-1:0]  chunk_bytes;
        logic [OFS_W-1:0]   buffer_bytes;
        logic [CNT_W-1:0]   chunk_count;
    } t_cfg;

    // A result that carries only a status and closes its request.
    function automatic t_result single_result(input logic [2:0] status);
        t_result r;
        r        = '0;
        r.status = status;
        r.last   = 1'b1;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/cos_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cos_front
// Takes requests, decodes their mode and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module cos_front (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire cos_pkg::t_in_item i_item,
    input  wire                    i_pop,
    output logic                   o_head_valid,
    output cos_pkg::t_cmd          o_head
);
    import cos_pkg::*;

    t_cmd       r_q [0:1];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    // Decode the request mode into an operation class.
    always_comb begin
        w_cmd             = '0;
        w_cmd.byte_offset = i_item.byte_offset;
        w_cmd.byte_count  = i_item.byte_count;
        w_cmd.entry_index = i_item.entry_index;
        w_cmd.entry_size  = i_item.entry_size;
        case (i_item.mode)
            MODE_LOAD:  w_cmd.op = OP_LOAD;
            MODE_READ:  w_cmd.op = OP_READ;
            MODE_WRITE: w_cmd.op = OP_WRITE;
            MODE_MARK:  w_cmd.op = OP_MARK;
            MODE_CLEAR: w_cmd.op = OP_CLEAR;
            default:    w_cmd.op = OP_BAD;
        endcase
    end

    assign o_stall      = (r_cnt == 2'd2);
    assign w_push       = i_valid && !o_stall;
    assign w_pop        = i_pop && (r_cnt != 2'd0);
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_q[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== sv/cos_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cos_div
// Restoring divider, one quotient bit per cycle, for offsets by chunk size.
// ---------------------------------------------------------------------------
module cos_div (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [39:0] i_dividend,
    input  wire  [31:0] i_divisor,
    output logic        o_done,
    output logic [39:0] o_quot,
    output logic [31:0] o_rem
);
    import cos_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [39:0]          r_q;
    logic [31:0]          r_rem;
    logic [32:0]          w_trial;
    logic [32:0]          w_diff;
    logic                 w_ge;

    // One shift-and-subtract step.
    assign w_trial = {r_rem, r_q[39]};
    assign w_ge    = (w_trial >= {1'b0, i_divisor});
    assign w_diff  = w_trial - {1'b0, i_divisor};

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

    // Control of the step sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient and partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[38:0], w_ge};
            r_rem <= w_ge ? w_diff[31:0] : w_trial[31:0];
        end
    end

endmodule
`default_nettype wire

// ===== sv/cos_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cos_back
// Sequencer that works one request at a time: geometry, bounds, locating the
// first chunk and walking the chunks, one segment result per step.
// ---------------------------------------------------------------------------
module cos_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire cos_pkg::t_cfg  i_cfg,
    input  wire                 i_head_valid,
    input  wire cos_pkg::t_cmd  i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_stall,
    output cos_pkg::t_result    o_result
);
    import cos_pkg::*;

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [31:0]       r_rem, n_rem;
    logic [39:0]       r_total, n_total;
    logic              r_good, n_good;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [39:0]       r_start, n_start;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [31:0]       r_coff, n_coff;
    logic [39:0]       r_remain, n_remain;
    logic [39:0]       r_host, n_host;
    logic [CNT_W-1:0]  r_k, n_k;
    t_result           r_pend, n_pend;
    logic              r_pend_v, n_pend_v;
    logic [MAX_CHUNKS-1:0] r_present, n_present;
    t_result           r_out;
    logic              r_out_v;

    // Size table with one valid bit per entry; unwritten entries read zero.
    logic [31:0]           r_tab [0:MAX_CHUNKS-1];
    logic [MAX_CHUNKS-1:0] r_tab_vld;
    logic [31:0]           r_rd_data;
    logic                  r_rd_vld;
    logic [CHUNK_W-1:0]    w_rd_addr;
    logic                  w_tab_we;

    logic        w_div_start;
    logic [39:0] w_div_dividend;
    logic        w_div_done;
    logic [39:0] w_quot;
    logic [31:0] w_drem;

    logic        w_out_free;
    logic        w_push;
    logic [31:0] w_len_var;
    logic [31:0] w_len;
    logic [31:0] w_avail;
    logic [31:0] w_seg;
    logic [39:0] w_rel;
    logic        w_over;
    t_result     w_res;

    cos_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (i_cfg.chunk_bytes),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_drem)
    );

    assign w_out_free = !r_out_v || !i_stall;
    assign o_valid    = r_out_v;
    assign o_result   = r_out;
    // The walk keeps the current chunk's entry on the read port while it
    // waits for the output, so a stalled step still sees its own size.
    assign w_rd_addr  = ((r_state == S_SEG_RD) || (r_state == S_SEG_GO)) ?
                        r_idx[CHUNK_W-1:0] : r_i[CHUNK_W-1:0];
    assign w_len_var  = r_rd_vld ? r_rd_data : 32'd0;

    // Length of the current chunk and of the segment taken from it.
    always_comb begin
        if (i_cfg.size_mode) begin
            w_len = w_len_var;
        end else if ((r_idx + 1'b1 == r_n) && (r_rem != 32'd0)) begin
            w_len = r_rem;
        end else begin
            w_len = i_cfg.chunk_bytes;
        end
        w_avail = w_len - r_coff;
        w_seg   = ({8'd0, w_avail} > r_remain) ? r_remain[31:0] : w_avail;
        w_rel   = r_cmd.byte_offset - r_start;
        w_over  = (r_cmd.byte_count > r_total) ||
                  (r_cmd.byte_offset > r_total - r_cmd.byte_count);
        w_res               = '0;
        w_res.chunk_index   = r_idx[CHUNK_W-1:0];
        w_res.chunk_pos     = r_coff;
        w_res.segment_bytes = w_seg;
        w_res.host_offset   = r_host;
    end

    // Next state and datapath.
    always_comb begin
        n_state        = r_state;
        n_cmd          = r_cmd;
        n_n            = r_n;
        n_rem          = r_rem;
        n_total        = r_total;
        n_good         = r_good;
        n_i            = r_i;
        n_start        = r_start;
        n_idx          = r_idx;
        n_coff         = r_coff;
        n_remain       = r_remain;
        n_host         = r_host;
        n_k            = r_k;
        n_pend         = r_pend;
        n_pend_v       = r_pend_v;
        n_present      = r_present;
        o_pop          = 1'b0;
        w_tab_we       = 1'b0;
        w_div_start    = 1'b0;
        w_div_dividend = i_cfg.buffer_bytes;
        w_push         = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_head_valid) begin
                    o_pop = 1'b1;
                    n_cmd = i_head;
                    case (i_head.op)
                        OP_LOAD: begin
                            w_tab_we = 1'b1;
                            n_pend   = single_result(STAT_OK);
                            n_pend_v = 1'b1;
                            n_state  = S_FLUSH;
                        end
                        OP_CLEAR: begin
                            n_present = '0;
                            n_pend    = single_result(STAT_OK);
                            n_pend_v  = 1'b1;
                            n_state   = S_FLUSH;
                        end
                        OP_READ, OP_WRITE, OP_MARK: begin
                            if (!i_cfg.size_mode) begin
                                if (i_cfg.chunk_bytes == 32'd0) begin
                                    n_pend   = single_result(STAT_BAD);
                                    n_pend_v = 1'b1;
                                    n_state  = S_FLUSH;
                                end else begin
                                    w_div_start = 1'b1;
                                    n_state     = S_DIV_TOT;
                                end
                            end else if (i_cfg.chunk_count > CNT_W'(MAX_CHUNKS)) begin
                                n_pend   = single_result(STAT_BAD);
                                n_pend_v = 1'b1;
                                n_state  = S_FLUSH;
                            end else begin
                                n_n     = i_cfg.chunk_count;
                                n_good  = 1'b1;
                                n_i     = '0;
                                n_start = '0;
                                n_state = (i_head.op == OP_MARK) ? S_CHECK : S_SUM_RD;
                            end
                        end
                        default: begin
                            n_pend   = single_result(STAT_BAD);
                            n_pend_v = 1'b1;
                            n_state  = S_FLUSH;
                        end
                    endcase
                end
            end
            S_DIV_TOT: begin
                if (w_div_done) begin
                    n_rem   = w_drem;
                    n_total = i_cfg.buffer_bytes;
                    n_good  = (w_quot < 40'(MAX_CHUNKS)) ||
                              ((w_quot == 40'(MAX_CHUNKS)) && (w_drem == 32'd0));
                    n_n     = w_quot[CNT_W-1:0] + CNT_W'(w_drem != 32'd0);
                    n_state = S_CHECK;
                end
            end
            // Sum of the table entries in use.
            S_SUM_RD: begin
                if (r_i >= r_n) begin
                    n_total = r_start;
                    n_state = S_CHECK;
                end else begin
                    n_state = S_SUM_GO;
                end
            end
            S_SUM_GO: begin
                n_start = r_start + {8'd0, w_len_var};
                n_i     = r_i + 1'b1;
                n_state = S_SUM_RD;
            end
            S_CHECK: begin
                n_remain = r_cmd.byte_count;
                n_host   = '0;
                n_k      = '0;
                n_pend_v = 1'b1;
                n_state  = S_FLUSH;
                if (!r_good) begin
                    n_pend = single_result(STAT_BAD);
                end else if (r_cmd.op == OP_MARK) begin
                    if (!i_cfg.contiguous || (r_n == '0)) begin
                        n_pend = single_result(STAT_BAD);
                    end else begin
                        for (int j = 0; j < MAX_CHUNKS; j++) begin
                            if (CNT_W'(j) < r_n) begin
                                n_present[j] = 1'b1;
                            end
                        end
                        n_pend = single_result(STAT_OK);
                    end
                end else if (w_over) begin
                    n_pend = single_result(STAT_OOB);
                end else if (r_cmd.byte_count == 40'd0) begin
                    n_pend = single_result(STAT_OK);
                end else begin
                    n_pend_v = 1'b0;
                    if (!i_cfg.size_mode) begin
                        w_div_start    = 1'b1;
                        w_div_dividend = r_cmd.byte_offset;
                        n_state        = S_DIV_OFF;
                    end else begin
                        n_i     = '0;
                        n_start = '0;
                        n_state = S_LOC_RD;
                    end
                end
            end
            S_DIV_OFF: begin
                if (w_div_done) begin
                    n_idx   = w_quot[CNT_W-1:0];
                    n_coff  = w_drem;
                    n_state = S_SEG_RD;
                end
            end
            // Walk the table to the chunk that holds the start offset.
            S_LOC_RD: begin
                if (r_i >= r_n) begin
                    n_idx   = r_n;
                    n_coff  = '0;
                    n_state = S_SEG_RD;
                end else begin
                    n_state = S_LOC_GO;
                end
            end
            S_LOC_GO: begin
                if (w_rel < {8'd0, w_len_var}) begin
                    n_idx   = r_i;
                    n_coff  = w_rel[31:0];
                    n_state = S_SEG_RD;
                end else begin
                    n_start = r_start + {8'd0, w_len_var};
                    n_i     = r_i + 1'b1;
                    n_state = S_LOC_RD;
                end
            end
            S_SEG_RD: begin
                if ((r_remain == 40'd0) || (r_idx >= r_n) || (r_k == CNT_W'(MAX_CHUNKS))) begin
                    if (r_pend_v) begin
                        n_pend.last = 1'b1;
                    end else begin
                        n_pend = single_result(STAT_OK);
                    end
                    n_pend_v = 1'b1;
                    n_state  = S_FLUSH;
                end else begin
                    n_state = S_SEG_GO;
                end
            end
            S_SEG_GO: begin
                if (w_len == 32'd0) begin
                    // Empty chunks give no segment.
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SEG_RD;
                end else if (!r_pend_v || w_out_free) begin
                    w_push   = r_pend_v;
                    n_pend_v = 1'b1;
                    n_pend   = w_res;
                    if (!r_present[r_idx[CHUNK_W-1:0]] &&
                        ((r_cmd.op == OP_READ) || i_cfg.contiguous)) begin
                        n_pend.status = (r_cmd.op == OP_READ) ? STAT_ABSENT : STAT_CONTIG;
                        n_pend.last   = 1'b1;
                        n_state       = S_FLUSH;
                    end else begin
                        n_pend.allocate_now = !r_present[r_idx[CHUNK_W-1:0]];
                        n_present[r_idx[CHUNK_W-1:0]] = 1'b1;
                        n_remain = r_remain - {8'd0, w_seg};
                        n_host   = r_host + {8'd0, w_seg};
                        n_coff   = '0;
                        n_idx    = r_idx + 1'b1;
                        n_k      = r_k + 1'b1;
                        n_state  = S_SEG_RD;
                    end
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    w_push   = 1'b1;
                    n_pend_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers that reset clears.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v  <= 1'b0;
            r_present <= '0;
            r_tab_vld <= '0;
            r_out_v   <= 1'b0;
        end else begin
            r_pend_v  <= n_pend_v;
            r_present <= n_present;
            if (w_tab_we) begin
                r_tab_vld[i_head.entry_index] <= 1'b1;
            end
            if (w_push) begin
                r_out_v <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Working registers of the current request.
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_n      <= n_n;
        r_rem    <= n_rem;
        r_total  <= n_total;
        r_good   <= n_good;
        r_i      <= n_i;
        r_start  <= n_start;
        r_idx    <= n_idx;
        r_coff   <= n_coff;
        r_remain <= n_remain;
        r_host   <= n_host;
        r_k      <= n_k;
        r_pend   <= n_pend;
        if (w_push) begin
            r_out <= r_pend;
        end
    end

    // Size table memory with registered read.
    always_ff @(posedge i_clk) begin
        if (w_tab_we) begin
            r_tab[i_head.entry_index] <= i_head.entry_size;
        end
        r_rd_data <= r_tab[w_rd_addr];
        r_rd_vld  <= r_tab_vld[w_rd_addr];
    end

endmodule
`default_nettype wire

// ===== sv/chunked_offset_segmenter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// chunked_offset_segmenter_unit
// Splits a byte range of a chunked buffer into per-chunk segment results.
// ---------------------------------------------------------------------------
// Requests enter a two-entry queue and are then worked one at a time by the
// sequencer. Size loads, clears and rejected requests give a single result.
// In fixed mode a read, write or mark runs the shared 40-step divider once
// for the chunk count and, for reads and writes, once more for the start
// chunk before walking the chunks. In variable mode the table's single read
// port sets the pace: for a read or write it sums the entry sizes, passes
// entries while locating the start, and walks the chunks. Results leave
// through an output register, one per cycle at most while the output does
// not stall.
module chunked_offset_segmenter_unit (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire cos_pkg::t_in_item i_item,
    output logic                   o_valid,
    input  wire                    i_stall,
    output cos_pkg::t_result       o_result,
    input  wire                    i_cfg_we,
    input  wire  [2:0]             i_cfg_idx,
    input  wire  [39:0]            i_cfg_data
);
    import cos_pkg::*;

    t_cfg r_cfg;
    logic w_head_valid;
    t_cmd w_head;
    logic w_pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.size_mode    <= 1'b0;
            r_cfg.contiguous   <= 1'b0;
            r_cfg.chunk_bytes  <= 32'd1;
            r_cfg.buffer_bytes <= 40'd0;
            r_cfg.chunk_count  <= 7'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIZE_MODE:    r_cfg.size_mode    <= i_cfg_data[0];
                CFG_CONTIGUOUS:   r_cfg.contiguous   <= i_cfg_data[0];
                CFG_CHUNK_BYTES:  r_cfg.chunk_bytes  <= i_cfg_data[31:0];
                CFG_BUFFER_BYTES: r_cfg.buffer_bytes <= i_cfg_data;
                CFG_CHUNK_COUNT:  r_cfg.chunk_count  <= i_cfg_data[6:0];
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    cos_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_item       (i_item),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    cos_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_result     (o_result)
    );

    // Every error result closes its request.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.status != STAT_OK) |-> o_result.last)
        else $error("error result without last");

    // Allocation is only reported on a good segment.
    a_alloc_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.allocate_now |-> (o_result.status == STAT_OK))
        else $error("allocation on an error result");

    // A segment that is not the final result always moves bytes.
    a_seg_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_result.status == STAT_OK) && !o_result.last
        |-> (o_result.segment_bytes != 32'd0))
        else $error("empty intermediate segment");

endmodule
`default_nettype wire
